// ===== hdl/nmea_sentence_framer_top_assert.svh =====
// ----------------------------------------------------------------------------
// nmea sentence framer assertion macros
// concurrent checks that vanish when the design is built for synthesis
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define NSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/nmea_sf_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea sentence framer package
// character codes, status and type codes, address tables, apb request bundle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nmea_sf_pkg;

    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LENGTH = '0;
    localparam logic [7:0]            MAX_LENGTH_RST  = 8'd82;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ST_CHECKSUM  = 3'd2;
    localparam logic [2:0] ST_NO_CR     = 3'd3;
    localparam logic [2:0] ST_NO_LF     = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    localparam logic [1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [1:0] TYPE_GPGGA   = 2'd1;
    localparam logic [1:0] TYPE_GPRMC   = 2'd2;

    localparam int unsigned ADDR_CHARS = 5;

    localparam logic [7:0] ADDR_GGA [ADDR_CHARS] = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
    localparam logic [7:0] ADDR_RMC [ADDR_CHARS] = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    typedef struct packed {
        logic                  psel;
        logic                  penable;
        logic                  pwrite;
        logic [APB_ADDR_W-1:0] paddr;
        logic [APB_DATA_W-1:0] pwdata;
    } t_apb_req;

    // uppercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'hA) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nmea_sf_if.sv =====
// ----------------------------------------------------------------------------
// nmea sentence framer channels
// byte input channel and result output channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nmea_sf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface nmea_sf_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] frame_length;
    logic [1:0] sentence_type;
    logic [7:0] computed_sum;

    modport source (output valid, output status, output frame_length,
                    output sentence_type, output computed_sum, input ready);
    modport sink   (input valid, input status, input frame_length,
                    input sentence_type, input computed_sum, output ready);
endinterface

`default_nettype wire

// ===== hdl/nmea_sf_cfg.sv =====
// ----------------------------------------------------------------------------
// nmea sentence framer configuration registers
// apb write and read of the maximum sentence length
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmea_sf_cfg
    import nmea_sf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_apb_req              i_req,
    output logic      [APB_DATA_W-1:0] o_prdata,
    output logic      [7:0]            o_max_length
);

    logic [7:0] r_max_length;
    logic       wr_hit;

    assign wr_hit = i_req.psel && i_req.penable && i_req.pwrite
                    && (i_req.paddr == ADDR_MAX_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (wr_hit) begin
            r_max_length <= i_req.pwdata[7:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_req.paddr == ADDR_MAX_LENGTH) begin
            o_prdata = {{(APB_DATA_W-8){1'b0}}, r_max_length};
        end
    end

    assign o_max_length = r_max_length;

endmodule

`default_nettype wire

// ===== hdl/nmea_sentence_framer_top.sv =====
// ----------------------------------------------------------------------------
// nmea sentence framer
// frames nmea 0183 sentences from a byte stream and checks their checksums
// ----------------------------------------------------------------------------
// usage
//   i_byte is a valid/ready byte channel; a byte transfers when valid and
//   ready are both high. every byte is handled in the cycle of its transfer.
//   o_res carries one result per finished or failed sentence: status,
//   frame length, sentence type and computed xor. a result appears in the
//   cycle after the byte that ends the sentence and holds until taken.
//   throughput is one byte per cycle; the per-byte step is a single pass of
//   compare and xor logic between the state registers and the result
//   register. while a result waits with o_res.ready low, i_byte.ready drops
//   for bytes; a result taken in the same cycle frees the slot at once.
//   max_length sits at apb address 0 (reset 82). the user must write it only
//   while no sentence result is pending; the block does not enforce it. pready is tied high.
//   reset (synchronous, active low) returns the framer to hunting for a
//   dollar sign and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nmea_sentence_framer_top_assert.svh"

module nmea_sentence_framer_top
    import nmea_sf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    nmea_sf_byte_if.sink               i_byte,
    nmea_sf_res_if.source              o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_BODY,
        PH_HEXHI,
        PH_HEXLO,
        PH_CR,
        PH_LF
    } t_phase;

    t_apb_req   apb_req;
    logic [7:0] max_length;

    assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                       paddr: paddr, pwdata: pwdata};
    assign pready  = 1'b1;

    nmea_sf_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (apb_req),
        .o_prdata     (prdata),
        .o_max_length (max_length)
    );

    t_phase     r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_cnt, n_cnt;
    logic       r_gga, n_gga;
    logic       r_rmc, n_rmc;

    logic       r_out_valid;
    logic [2:0] r_status;
    logic [7:0] r_len;
    logic [1:0] r_type;
    logic [7:0] r_sum;

    logic       in_xfer;
    logic [7:0] b;
    logic [8:0] newlen;
    logic       addr_seen;
    logic [2:0] pos;
    logic       res_valid;
    logic [2:0] res_status;

    assign i_byte.ready = !r_out_valid || o_res.ready;
    assign in_xfer      = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;
    assign newlen       = {1'b0, r_cnt} + 9'd1;
    assign addr_seen    = (r_phase != PH_BODY) || (r_cnt >= 8'd6);
    assign pos          = 3'(r_cnt - 8'd1);

    always_comb begin
        n_phase    = r_phase;
        n_xor      = r_xor;
        n_cnt      = r_cnt;
        n_gga      = r_gga;
        n_rmc      = r_rmc;
        res_valid  = 1'b0;
        res_status = ST_OK;
        if (r_phase == PH_HUNT) begin
            if (b == CH_DOLLAR) begin
                n_phase = PH_BODY;
                n_xor   = '0;
                n_cnt   = 8'd1;
                n_gga   = 1'b1;
                n_rmc   = 1'b1;
            end
        end else if (r_cnt >= max_length) begin
            res_valid  = 1'b1;
            res_status = ST_TOO_LONG;
        end else begin
            n_cnt = newlen[7:0];
            case (r_phase)
                PH_BODY: begin
                    if (b == CH_STAR) begin
                        if (newlen < 9'd7) begin
                            n_gga = 1'b0;
                            n_rmc = 1'b0;
                        end
                        n_phase = PH_HEXHI;
                    end else if (!(b inside {[8'h20:8'h7E]})) begin
                        res_valid  = 1'b1;
                        res_status = ST_BAD_CHAR;
                    end else begin
                        n_xor = r_xor ^ b;
                        // address characters sit at lengths two to six
                        if (newlen >= 9'd2 && newlen <= 9'd6) begin
                            if (b != ADDR_GGA[pos]) n_gga = 1'b0;
                            if (b != ADDR_RMC[pos]) n_rmc = 1'b0;
                        end
                    end
                end
                PH_HEXHI: begin
                    if (b != hex_char(r_xor[7:4])) begin
                        res_valid  = 1'b1;
                        res_status = ST_CHECKSUM;
                    end else begin
                        n_phase = PH_HEXLO;
                    end
                end
                PH_HEXLO: begin
                    if (b != hex_char(r_xor[3:0])) begin
                        res_valid  = 1'b1;
                        res_status = ST_CHECKSUM;
                    end else begin
                        n_phase = PH_CR;
                    end
                end
                PH_CR: begin
                    if (b != CH_CR) begin
                        res_valid  = 1'b1;
                        res_status = ST_NO_CR;
                    end else begin
                        n_phase = PH_LF;
                    end
                end
                PH_LF: begin
                    res_valid  = 1'b1;
                    res_status = (b != CH_LF) ? ST_NO_LF : ST_OK;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
        if (res_valid) begin
            n_phase = PH_HUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_xor       <= '0;
            r_cnt       <= '0;
            r_gga       <= 1'b1;
            r_rmc       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase <= n_phase;
                r_xor   <= n_xor;
                r_cnt   <= n_cnt;
                r_gga   <= n_gga;
                r_rmc   <= n_rmc;
            end
            if (in_xfer && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_xfer && res_valid) begin
            r_status <= res_status;
            r_len    <= newlen[8] ? 8'hFF : newlen[7:0];
            r_sum    <= r_xor;
            if (!addr_seen) begin
                r_type <= TYPE_UNKNOWN;
            end else if (r_gga) begin
                r_type <= TYPE_GPGGA;
            end else if (r_rmc) begin
                r_type <= TYPE_GPRMC;
            end else begin
                r_type <= TYPE_UNKNOWN;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.frame_length  = r_len;
    assign o_res.sentence_type = r_type;
    assign o_res.computed_sum  = r_sum;

    // a waiting result that is not taken must hold back input bytes
    `NSF_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !o_res.ready, !i_byte.ready, "byte accepted over a stalled result")

    // a dollar sign while hunting opens a sentence of length one
    `NSF_ASSERT_NEXT(a_dollar_opens, i_clk, i_rst_n, in_xfer && (r_phase == PH_HUNT) && (b == CH_DOLLAR), (r_phase == PH_BODY) && (r_cnt == 8'd1), "dollar sign did not open a sentence")

    // inside a sentence the byte count never sits at zero
    `NSF_ASSERT_IMPL(a_count_live, i_clk, i_rst_n, r_phase != PH_HUNT, r_cnt != 8'd0, "zero byte count inside a sentence")

    // a good sentence holds at least dollar, star, two digits, cr and lf
    `NSF_ASSERT_IMPL(a_ok_length, i_clk, i_rst_n, r_out_valid && (r_status == ST_OK), r_len >= 8'd6, "good sentence shorter than six bytes")

endmodule

`default_nettype wire
